// ----- rtl/sor_pkg.sv -----
// Shared types, codes and constants for the shape outline rasterizer.
// Holds the controller/datapath command and status structs and the
// elaboration-time trig table generator. Depends on nothing.
package sor_pkg;

  // Signed width used for rectangle corner arithmetic (11-bit position plus 10-bit size).
  localparam int CW = 13;

  localparam int ANGLE_STEPS = 629;
  localparam int ANGLE_W     = 10;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [1:0] FUNC_RECT = 2'd0;
  localparam logic [1:0] FUNC_OVAL = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // The four straight runs of a rectangle outline.
  typedef enum logic [1:0] {
    RUN_TOP    = 2'd0,
    RUN_RIGHT  = 2'd1,
    RUN_BOTTOM = 2'd2,
    RUN_LEFT   = 2'd3
  } sor_run_t;

  typedef struct packed {
    logic     load;
    logic     oval_start;
    logic     clr_step;
    logic     run_init;
    logic     run_step;
    logic     rd_issue;
    logic     out_load;
    sor_run_t run_sel;
  } sor_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_zero;
    logic oval_busy;
    logic out_free;
  } sor_status_t;

  // Cosine or sine of k/100 in signed Q2.fbits, rounded to nearest.
  // Evaluated only at elaboration to build the constant angle table.
  function automatic logic signed [63:0] trig_value(input int k, input int fbits,
                                                    input logic want_sin);
    logic [63:0]        theta;
    logic [63:0]        q;
    logic [63:0]        a;
    logic [63:0]        term;
    logic [63:0]        ur;
    logic signed [63:0] r;
    logic signed [63:0] cs;
    logic signed [63:0] sn;
    logic signed [63:0] cr;
    logic signed [63:0] sr;
    logic signed [63:0] res;
    int                 n;
    theta = ((64'(k) << 30) + 64'd50) / 64'd100;
    q     = (theta + HALF_PI_Q30 / 2) / HALF_PI_Q30;
    r     = $signed(theta) - $signed(q * HALF_PI_Q30);
    a     = (r < 0) ? 64'(-r) : 64'(r);
    term  = ONE_Q30;
    cs    = $signed(ONE_Q30);
    sn    = 64'sd0;
    for (n = 1; n <= 15; n++) begin
      term = ((term * a) >> 30) / 64'(n);
      unique case (n & 3)
        1:       sn = sn + $signed(term);
        2:       cs = cs - $signed(term);
        3:       sn = sn - $signed(term);
        default: cs = cs + $signed(term);
      endcase
    end
    ur = (64'(cs) + (64'd1 << (29 - fbits))) >> (30 - fbits);
    cr = $signed(ur);
    ur = (64'(sn) + (64'd1 << (29 - fbits))) >> (30 - fbits);
    sr = $signed(ur);
    if (r < 0) begin
      sr = -sr;
    end
    unique case (q[1:0])
      2'd0: res = want_sin ? sr : cr;
      2'd1: res = want_sin ? cr : -sr;
      2'd2: res = want_sin ? -sr : -cr;
      2'd3: res = want_sin ? -cr : sr;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/sor_trig_rom.sv -----
// Constant cosine/sine table over the ellipse angles, with a registered read.
// Table contents come from sor_pkg::trig_value at elaboration.
module sor_trig_rom
  import sor_pkg::*;
#(
  parameter int  TRIG_FRACTION_BITS = 16,
  localparam int TW                 = TRIG_FRACTION_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ANGLE_W-1:0]   addr,
  output logic signed [TW-1:0] cos_q,
  output logic signed [TW-1:0] sin_q
);

  logic signed [TW-1:0] cos_tab [ANGLE_STEPS];
  logic signed [TW-1:0] sin_tab [ANGLE_STEPS];

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_tab
    localparam logic signed [63:0] CV = trig_value(g, TRIG_FRACTION_BITS, 1'b0);
    localparam logic signed [63:0] SV = trig_value(g, TRIG_FRACTION_BITS, 1'b1);
    assign cos_tab[g] = CV[TW-1:0];
    assign sin_tab[g] = SV[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_q <= cos_tab[addr];
      sin_q <= sin_tab[addr];
    end
  end

endmodule

// ----- rtl/sor_datapath.sv -----
// Datapath: framebuffer memory, clear counter, rectangle run walker,
// ellipse angle pipeline and output register. Uses sor_pkg and sor_trig_rom.
module sor_datapath
  import sor_pkg::*;
#(
  parameter int IMAGE_SIZE         = 256,
  parameter int TRIG_FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sor_cmd_t           cmd,
  output sor_status_t        st,
  input  logic signed [10:0] in_pos_y,
  input  logic signed [10:0] in_pos_x,
  input  logic [9:0]         in_height,
  input  logic [9:0]         in_width,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         out_pixel_value
);

  localparam int F   = TRIG_FRACTION_BITS;
  localparam int AW  = $clog2(IMAGE_SIZE);
  localparam int ADW = 2 * AW;
  localparam int TW  = F + 2;
  localparam int PW  = TW + 10;
  localparam int SW  = F + 12;

  localparam logic signed [CW-1:0] LIM_C = CW'(IMAGE_SIZE);
  localparam logic signed [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [SW-1:0] LIM_F = SW'(longint'(IMAGE_SIZE - 1) << F);

  function automatic logic in_img(input logic signed [CW-1:0] c);
    return (c >= 0) && (c < LIM_C);
  endfunction

  // Latched command fields.
  logic signed [10:0] pos_y_r, pos_x_r;
  logic [9:0]         height_r, width_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_y_r  <= in_pos_y;
      pos_x_r  <= in_pos_x;
      height_r <= in_height;
      width_r  <= in_width;
    end
  end

  logic signed [CW-1:0] top_c, left_c, wid_c, hgt_c;
  assign top_c  = {{(CW - 11){pos_y_r[10]}}, pos_y_r};
  assign left_c = {{(CW - 11){pos_x_r[10]}}, pos_x_r};
  assign wid_c  = {{(CW - 10){1'b0}}, width_r};
  assign hgt_c  = {{(CW - 10){1'b0}}, height_r};

  // Clear pass after reset; memory bit set means ink.
  logic [ADW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ADW'(1);
    end
  end

  // Rectangle run walker: one fixed coordinate, one that counts up.
  logic signed [CW-1:0] run_fix_r, run_var_r, run_fix_nxt, run_var_nxt;
  logic [9:0]           run_cnt_r, run_cnt_nxt;
  logic                 run_vert_r, run_vert_nxt;
  logic signed [CW-1:0] run_x, run_y;
  logic                 run_ok;

  always_comb begin
    unique case (cmd.run_sel)
      RUN_TOP: begin
        run_fix_nxt  = top_c;
        run_var_nxt  = left_c;
        run_cnt_nxt  = width_r;
        run_vert_nxt = 1'b0;
      end
      RUN_RIGHT: begin
        run_fix_nxt  = left_c + wid_c;
        run_var_nxt  = top_c;
        run_cnt_nxt  = height_r;
        run_vert_nxt = 1'b1;
      end
      RUN_BOTTOM: begin
        run_fix_nxt  = top_c + hgt_c;
        run_var_nxt  = left_c + ONE_C;
        run_cnt_nxt  = width_r;
        run_vert_nxt = 1'b0;
      end
      RUN_LEFT: begin
        run_fix_nxt  = left_c;
        run_var_nxt  = top_c + ONE_C;
        run_cnt_nxt  = height_r;
        run_vert_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      run_fix_r  <= run_fix_nxt;
      run_var_r  <= run_var_nxt;
      run_cnt_r  <= run_cnt_nxt;
      run_vert_r <= run_vert_nxt;
    end else if (cmd.run_step) begin
      run_var_r <= run_var_r + ONE_C;
      run_cnt_r <= run_cnt_r - 10'd1;
    end
  end

  assign run_y  = run_vert_r ? run_var_r : run_fix_r;
  assign run_x  = run_vert_r ? run_fix_r : run_var_r;
  assign run_ok = in_img(run_x) && in_img(run_y);

  // Ellipse pipeline: angle counter, table read, multiply, offset add.
  logic [ANGLE_W-1:0]   k_r;
  logic                 issue_r, a_v_r, b_v_r, c_v_r;
  logic signed [TW-1:0] cos_q, sin_q;
  logic signed [PW-1:0] prod_x_r, prod_y_r;
  logic signed [SW-1:0] px_r, py_r;
  logic signed [9:0]    rx_s, ry_s;
  logic                 oval_ok;

  assign rx_s = $signed({1'b0, width_r[9:1]});
  assign ry_s = $signed({1'b0, height_r[9:1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      k_r     <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
    end else begin
      if (cmd.oval_start) begin
        issue_r <= 1'b1;
        k_r     <= '0;
      end else if (issue_r) begin
        k_r <= k_r + ANGLE_W'(1);
        if (k_r == ANGLE_W'(ANGLE_STEPS - 1)) begin
          issue_r <= 1'b0;
        end
      end
      a_v_r <= issue_r;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  sor_trig_rom #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_rom (
    .clk   (clk),
    .rd_en (issue_r),
    .addr  (k_r),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    if (a_v_r) begin
      prod_x_r <= PW'(rx_s * cos_q);
      prod_y_r <= PW'(ry_s * sin_q);
    end
    if (b_v_r) begin
      px_r <= SW'(prod_x_r) + (SW'(pos_x_r) <<< F);
      py_r <= SW'(prod_y_r) + (SW'(pos_y_r) <<< F);
    end
  end

  assign oval_ok = (px_r > 0) && (px_r < LIM_F) && (py_r > 0) && (py_r < LIM_F);

  // Framebuffer: one write port, one registered read port.
  logic           fb_mem [2**ADW];
  logic           we, wdata, fb_q_r;
  logic [ADW-1:0] waddr, raddr;
  logic           rd_ok, rd_ok_r;

  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    waddr = clr_cnt_r;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.run_step && run_ok) begin
      we    = 1'b1;
      wdata = 1'b1;
      waddr = {run_y[AW-1:0], run_x[AW-1:0]};
    end else if (c_v_r && oval_ok) begin
      we    = 1'b1;
      wdata = 1'b1;
      waddr = {py_r[F +: AW], px_r[F +: AW]};
    end
  end

  assign rd_ok = in_img(top_c) && in_img(left_c);
  assign raddr = {top_c[AW-1:0], left_c[AW-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      fb_mem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      fb_q_r  <= fb_mem[raddr];
      rd_ok_r <= rd_ok;
    end
  end

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r <= (rd_ok_r && !fb_q_r) ? 8'hFF : 8'h00;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;

  assign st.clr_last  = (clr_cnt_r == '1);
  assign st.run_zero  = (run_cnt_r == 10'd0);
  assign st.oval_busy = issue_r | a_v_r | b_v_r | c_v_r;
  assign st.out_free  = !out_valid_r || !out_stall;

endmodule

// ----- rtl/sor_ctrl.sv -----
// Controller state machine: clear pass, command dispatch, rectangle run
// sequencing, ellipse wait and pixel read. Uses sor_pkg command/status types.
module sor_ctrl
  import sor_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  output logic        in_stall,
  output sor_cmd_t    cmd,
  input  sor_status_t st
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_RECT_INIT = 7'b0000100,
    S_RECT_RUN  = 7'b0001000,
    S_OVAL      = 7'b0010000,
    S_RD_WAIT   = 7'b0100000,
    S_RD_DATA   = 7'b1000000
  } sor_state_t;

  sor_state_t state_r, state_nxt;
  sor_run_t   run_idx_r, run_idx_nxt;
  logic       accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    run_idx_nxt     = run_idx_r;
    cmd             = '0;
    cmd.run_sel     = run_idx_r;
    cmd.load        = accept;
    cmd.oval_start  = accept && (in_func == FUNC_OVAL);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_RECT: begin
              run_idx_nxt = RUN_TOP;
              state_nxt   = S_RECT_INIT;
            end
            FUNC_OVAL: state_nxt = S_OVAL;
            FUNC_READ: state_nxt = S_RD_WAIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RECT_INIT: begin
        cmd.run_init = 1'b1;
        state_nxt    = S_RECT_RUN;
      end
      S_RECT_RUN: begin
        if (st.run_zero) begin
          if (run_idx_r == RUN_LEFT) begin
            state_nxt = S_IDLE;
          end else begin
            run_idx_nxt = sor_run_t'(run_idx_r + 2'd1);
            state_nxt   = S_RECT_INIT;
          end
        end else begin
          cmd.run_step = 1'b1;
        end
      end
      S_OVAL: begin
        if (!st.oval_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        // The output register is empty by the next edge, so the read may go out.
        if (st.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      run_idx_r <= RUN_TOP;
    end else begin
      state_r   <= state_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

endmodule

// ----- rtl/shape_outline_rasterizer.sv -----
// Top level of the shape outline rasterizer: controller plus datapath.
// Depends on sor_pkg, sor_ctrl and sor_datapath.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_func, in_pos_y, in_pos_x, in_height, in_width
//   out     | output    | out_valid/out_stall | out_pixel_value (read commands only)
//
// One command at a time. A rectangle writes one outline pixel per cycle within each
// of its four runs, through the single framebuffer write port. An ellipse steps
// through 629 angles, one angle per cycle through the table/multiply/add pipeline.
// A read is held back for any time the previous result still waits.
// After reset a clearing pass writes 2**(2*clog2(IMAGE_SIZE)) entries, one per
// cycle (65536 at the default size), with in_stall high throughout.
// Draw commands continue while a result is stalled; only a read waits for it.
module shape_outline_rasterizer
  import sor_pkg::*;
#(
  parameter int IMAGE_SIZE         = 256,
  parameter int TRIG_FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [10:0] in_pos_y,
  input  logic signed [10:0] in_pos_x,
  input  logic [9:0]         in_height,
  input  logic [9:0]         in_width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pixel_value
);

  sor_cmd_t    cmd;
  sor_status_t st;

  sor_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  sor_datapath #(
    .IMAGE_SIZE         (IMAGE_SIZE),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_pos_y        (in_pos_y),
    .in_pos_x        (in_pos_x),
    .in_height       (in_height),
    .in_width        (in_width),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value)
  );

endmodule

// ----- rtl/sor_checker.sv -----
// Port-level checker for the shape outline rasterizer, bound to the top level.
// Depends on sor_pkg for the function codes.
module sor_checker
  import sor_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_pixel_value
);

  logic in_beat, read_beat, new_beat;
  logic hold_r, pend_r;

  assign in_beat   = in_valid && !in_stall;
  assign read_beat = in_beat && (in_func == FUNC_READ);
  assign new_beat  = out_valid && !hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      hold_r <= out_valid && out_stall;
      if (read_beat) begin
        pend_r <= 1'b1;
      end else if (new_beat) begin
        pend_r <= 1'b0;
      end
    end
  end

  // The clearing pass keeps the input closed right after reset.
  a_clear_stall: assert property (@(posedge clk) $past(!rst_n) |-> in_stall)
    else $error("input open right after reset");

  // Only ink or paper can ever be read back.
  a_pixel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_value == 8'h00 || out_pixel_value == 8'hFF))
    else $error("pixel value is neither ink nor paper");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_value))
    else $error("stalled result changed");

  // Every fresh result beat answers an accepted read.
  a_beat_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    new_beat |-> pend_r)
    else $error("result beat without a read command");

  // No command is taken while a read result is still owed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !new_beat |-> !in_beat)
    else $error("command accepted while a read is outstanding");

endmodule

bind shape_outline_rasterizer sor_checker u_sor_checker (.*);

// ----- bench/tb_shape_outline_rasterizer.sv -----
// Testbench for shape_outline_rasterizer: directed table plus random draw/read sequences.
// Keeps its own framebuffer and trig table and checks every read beat.
// Depends on sor_pkg and the RTL of shape_outline_rasterizer.
`timescale 1ns / 1ps

module tb_shape_outline_rasterizer;
  import sor_pkg::*;

  localparam int IMAGE_SIZE   = 256;
  localparam int FRAC         = 16;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_ITEMS   = 555;
  localparam int HOLD_CYCLES  = 2500;
  // Drain time covering the largest rectangle, with room to spare.
  localparam int DRAIN_CYCLES = 4300;
  // The clearing pass after reset gives no beat at all.
  localparam int QUIET_LIMIT  = 300000;

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [10:0] pos_y;
    logic signed [10:0] pos_x;
    logic [9:0]         height;
    logic [9:0]         width;
    logic               fixed;
    logic [7:0]         fixed_val;
  } cmd_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FUNC_READ;
  logic signed [10:0] in_pos_y = '0;
  logic signed [10:0] in_pos_x = '0;
  logic [9:0]         in_height = '0;
  logic [9:0]         in_width = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_pixel_value;

  logic [7:0] frame_model [IMAGE_SIZE * IMAGE_SIZE];
  longint     cos_rom [ANGLE_STEPS];
  longint     sin_rom [ANGLE_STEPS];
  logic [7:0] pixel_expect_q [$];
  cmd_t       cmd_q [$];
  logic [7:0] want_px;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         random_phase = 1'b0;

  cmd_t dir_tab [DIR_ROWS] = '{
    '{FUNC_READ,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1, 8'd255},
    '{FUNC_READ,  11'sd255,   11'sd255,   10'd0,    10'd0,    1'b1, 8'd255},
    '{FUNC_READ,  -11'sd1,    11'sd5,     10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_READ,  11'sd5,     11'sd256,   10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_READ,  -11'sd1024, 11'sd1023,  10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_READ,  11'sd1023,  -11'sd1024, 10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_RECT,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_READ,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1, 8'd255},
    '{FUNC_RECT,  11'sd10,    11'sd10,    10'd5,    10'd5,    1'b0, 8'd0},
    '{FUNC_READ,  11'sd10,    11'sd10,    10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_READ,  11'sd15,    11'sd15,    10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_READ,  11'sd11,    11'sd11,    10'd0,    10'd0,    1'b1, 8'd255},
    '{FUNC_RECT,  11'sd0,     11'sd0,     10'd1023, 10'd1023, 1'b0, 8'd0},
    '{FUNC_READ,  11'sd0,     11'sd200,   10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_READ,  11'sd200,   11'sd0,     10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_RECT,  -11'sd1024, -11'sd1024, 10'd1023, 10'd1023, 1'b0, 8'd0},
    '{FUNC_OVAL,  11'sd128,   11'sd128,   10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_READ,  11'sd128,   11'sd128,   10'd0,    10'd0,    1'b1, 8'd0},
    '{FUNC_OVAL,  11'sd255,   11'sd255,   10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_READ,  11'sd255,   11'sd255,   10'd0,    10'd0,    1'b1, 8'd255},
    '{FUNC_OVAL,  11'sd128,   11'sd128,   10'd1023, 10'd1023, 1'b0, 8'd0},
    '{FUNC_OVAL,  11'sd100,   11'sd60,    10'd81,   10'd41,   1'b0, 8'd0},
    '{FUNC_READ,  11'sd100,   11'sd80,    10'd0,    10'd0,    1'b0, 8'd0},
    '{FUNC_SPARE, -11'sd1,    -11'sd1,    10'd1023, 10'd1023, 1'b0, 8'd0},
    '{FUNC_READ,  11'sd50,    11'sd50,    10'd0,    10'd0,    1'b0, 8'd0}
  };

  shape_outline_rasterizer #(
    .IMAGE_SIZE        (IMAGE_SIZE),
    .TRIG_FRACTION_BITS(FRAC)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_pos_y       (in_pos_y),
    .in_pos_x       (in_pos_x),
    .in_height      (in_height),
    .in_width       (in_width),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_value(out_pixel_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Cosine and sine of k/100 in signed Q2.FRAC, by quadrant reduction and a Q30 series.
  function automatic void angle_entry(input int k, output longint cv, output longint sv);
    longint unsigned theta;
    longint unsigned half;
    longint unsigned a;
    longint unsigned term;
    longint          q;
    longint          r;
    longint          cs;
    longint          sn;
    longint          cr;
    longint          sr;
    int              n;
    half  = HALF_PI_Q30;
    theta = ((longint'(k) << 30) + 50) / 100;
    q     = longint'((theta + half / 2) / half);
    r     = longint'(theta) - q * longint'(half);
    a     = (r < 0) ? -r : r;
    term  = longint'(1) << 30;
    cs    = longint'(1) << 30;
    sn    = 0;
    for (n = 1; n <= 15; n++) begin
      term = ((term * a) >> 30) / n;
      case (n % 4)
        1:       sn = sn + longint'(term);
        2:       cs = cs - longint'(term);
        3:       sn = sn - longint'(term);
        default: cs = cs + longint'(term);
      endcase
    end
    cr = (cs + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    sr = (sn + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (r < 0) begin
      sr = -sr;
    end
    case (q % 4)
      0: begin cv = cr;  sv = sr;  end
      1: begin cv = -sr; sv = cr;  end
      2: begin cv = -cr; sv = -sr; end
      default: begin cv = sr; sv = -cr; end
    endcase
  endfunction

  task automatic paint_px(input int y, input int x);
    if (x >= 0 && x < IMAGE_SIZE && y >= 0 && y < IMAGE_SIZE) begin
      frame_model[y * IMAGE_SIZE + x] = 8'd0;
    end
  endtask

  task automatic model_rect(input int t, input int l, input int h, input int w);
    int i;
    for (i = l; i < l + w; i++) paint_px(t, i);
    for (i = t; i < t + h; i++) paint_px(i, l + w);
    for (i = l + w; i > l; i--) paint_px(t + h, i);
    for (i = t + h; i > t; i--) paint_px(i, l);
  endtask

  task automatic model_oval(input int cy, input int cx, input int h, input int w);
    longint rx;
    longint ry;
    longint one;
    longint lim;
    longint px;
    longint py;
    int     k;
    rx  = w / 2;
    ry  = h / 2;
    one = longint'(1) << FRAC;
    lim = longint'(IMAGE_SIZE - 1) * one;
    for (k = 0; k < ANGLE_STEPS; k++) begin
      px = rx * cos_rom[k] + longint'(cx) * one;
      py = ry * sin_rom[k] + longint'(cy) * one;
      if (px > 0 && px < lim && py > 0 && py < lim) begin
        paint_px(int'(py >>> FRAC), int'(px >>> FRAC));
      end
    end
  endtask

  // Updates the model for one accepted command and queues the pixel a read returns.
  task automatic apply_cmd(input cmd_t c);
    int         y;
    int         x;
    logic [7:0] v;
    y = c.pos_y;
    x = c.pos_x;
    case (c.func)
      FUNC_RECT: model_rect(y, x, int'(c.height), int'(c.width));
      FUNC_OVAL: model_oval(y, x, int'(c.height), int'(c.width));
      FUNC_READ: begin
        v = 8'd0;
        if (x >= 0 && x < IMAGE_SIZE && y >= 0 && y < IMAGE_SIZE) begin
          v = frame_model[y * IMAGE_SIZE + x];
        end
        pixel_expect_q.push_back(c.fixed ? c.fixed_val : v);
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [10:0] to_pos(input int v);
    int c;
    c = (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
    return c[10:0];
  endfunction

  function automatic logic signed [10:0] pick_pos();
    if ($urandom_range(0, 9) == 0) begin
      return 11'($urandom_range(0, 2047));
    end
    return to_pos(int'($urandom_range(0, 287)) - 16);
  endfunction

  function automatic cmd_t mk_cmd(input logic [1:0] f, input logic signed [10:0] y,
                                  input logic signed [10:0] x, input int h, input int w);
    cmd_t c;
    c.func      = f;
    c.pos_y     = y;
    c.pos_x     = x;
    c.height    = h[9:0];
    c.width     = w[9:0];
    c.fixed     = 1'b0;
    c.fixed_val = 8'd0;
    return c;
  endfunction

  // Result channel: compare every accepted beat and watch for a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_expect_q.size() == 0) begin
          $error("pixel_value: expected none, actual %0d", out_pixel_value);
          mismatches++;
        end else begin
          want_px = pixel_expect_q.pop_front();
          if (want_px !== out_pixel_value) begin
            $error("pixel_value: expected %0d, actual %0d", want_px, out_pixel_value);
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_shape_outline_rasterizer: done, errors");
        $finish;
      end
    end
  end

  // Receiver: one long hold-off once random traffic starts, otherwise mixed stall patterns.
  initial begin : result_sink
    int  mode;
    int  len;
    int  i;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && random_phase) begin
        held = 1'b1;
        for (i = 0; i < HOLD_CYCLES; i++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      for (i = 0; i < len; i++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= (i % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  initial begin : cmd_feed
    cmd_t   c;
    int     idx;
    int     burst;
    int     gap;
    int     counted;
    int     nreads;
    int     i;
    int     k;
    int     t;
    int     l;
    int     h;
    int     w;
    int     ty;
    int     tx;
    longint px;
    longint py;

    for (i = 0; i < IMAGE_SIZE * IMAGE_SIZE; i++) frame_model[i] = 8'd255;
    for (k = 0; k < ANGLE_STEPS; k++) angle_entry(k, cos_rom[k], sin_rom[k]);

    for (i = 0; i < DIR_ROWS; i++) cmd_q.push_back(dir_tab[i]);

    // Mostly a draw followed by reads aimed at its outline, with loose reads and noise.
    counted = 0;
    while (counted < RAND_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        t = pick_pos();
        l = pick_pos();
        if (k < 30) begin
          h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
          w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
          cmd_q.push_back(mk_cmd(FUNC_RECT, t[10:0], l[10:0], h, w));
        end else begin
          h = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 1023);
          w = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 1023);
          cmd_q.push_back(mk_cmd(FUNC_OVAL, t[10:0], l[10:0], h, w));
        end
        counted++;
        t = cmd_q[cmd_q.size() - 1].pos_y;
        l = cmd_q[cmd_q.size() - 1].pos_x;
        nreads = $urandom_range(1, 3);
        for (i = 0; i < nreads; i++) begin
          if (k < 30) begin
            case ($urandom_range(0, 3))
              0:       begin ty = t;                         tx = l + $urandom_range(0, w); end
              1:       begin ty = t + $urandom_range(0, h);  tx = l + w;                    end
              2:       begin ty = t + h;                     tx = l + $urandom_range(0, w); end
              default: begin ty = t + $urandom_range(0, h);  tx = l;                        end
            endcase
          end else begin
            gap = $urandom_range(0, ANGLE_STEPS - 1);
            px  = longint'(w / 2) * cos_rom[gap] + (longint'(l) << FRAC);
            py  = longint'(h / 2) * sin_rom[gap] + (longint'(t) << FRAC);
            tx  = int'(px >>> FRAC);
            ty  = int'(py >>> FRAC);
          end
          if ($urandom_range(0, 3) == 0) begin
            ty = ty + int'($urandom_range(0, 2)) - 1;
            tx = tx + int'($urandom_range(0, 2)) - 1;
          end
          cmd_q.push_back(mk_cmd(FUNC_READ, to_pos(ty), to_pos(tx), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023)));
          counted++;
        end
      end else if (k < 85) begin
        if ($urandom_range(0, 4) == 0) begin
          ty = $urandom_range(0, 2047);
          tx = $urandom_range(0, 2047);
        end else begin
          ty = int'($urandom_range(0, 263)) - 4;
          tx = int'($urandom_range(0, 263)) - 4;
        end
        cmd_q.push_back(mk_cmd(FUNC_READ, ty[10:0], tx[10:0], $urandom_range(0, 1023),
                               $urandom_range(0, 1023)));
        counted++;
      end else begin
        c = mk_cmd(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                   11'($urandom_range(0, 2047)),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (k < 95) begin
          c.func = FUNC_SPARE;
        end
        cmd_q.push_back(c);
        if (c.func != FUNC_SPARE) begin
          counted++;
        end
      end
    end

    wait (rst_n);
    @(negedge clk);
    idx   = 0;
    burst = $urandom_range(1, 24);
    while (idx < cmd_q.size()) begin
      if (idx >= DIR_ROWS) begin
        random_phase = 1'b1;
      end
      if (burst == 0) begin
        burst = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        gap   = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      c = cmd_q[idx];
      in_valid  <= 1'b1;
      in_func   <= c.func;
      in_pos_y  <= c.pos_y;
      in_pos_x  <= c.pos_x;
      in_height <= c.height;
      in_width  <= c.width;
      // The beat is taken at the first rising edge with the input not stalled.
      do @(posedge clk); while (in_stall);
      apply_cmd(c);
      idx++;
      burst--;
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_shape_outline_rasterizer: done, clean");
    end else begin
      $display("tb_shape_outline_rasterizer: done, errors");
    end
    $finish;
  end

endmodule
